FILE: rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants of the radix digit converter: radix limits and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rdc_pkg;

   // Digit and radix width
   localparam int DIGIT_BITS = 4;

   // Legal radix range and the value after reset
   localparam logic [DIGIT_BITS-1:0] RADIX_MIN   = 4'd2;
   localparam logic [DIGIT_BITS-1:0] RADIX_MAX   = 4'd10;
   localparam logic [DIGIT_BITS-1:0] RADIX_RESET = 4'd10;

   // Bits of the quotient resolved per divider cycle
   localparam int STEP_BITS = 8;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // take a new word, clear the digit stack
      logic div_step;  // run one divider cycle
      logic push;      // last divider cycle: push the remainder
      logic pop;       // read the top of the stack, drop it
      logic show;      // move the popped digit to the output register
   } rdc_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic quot_zero; // quotient is zero, conversion done
      logic full;      // digit stack is full
      logic last;      // shown digit is the final one
   } rdc_status_type;

endpackage

FILE: rtl/rdc_datapath.sv
// ----------------------------------------------------------------------------
// rdc_datapath
// Radix register, digit-serial divider (eight quotient bits per cycle),
// digit stack memory and the result register.
// ----------------------------------------------------------------------------
module rdc_datapath #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [rdc_pkg::DIGIT_BITS-1:0]   csr_write_data,
   input  logic [VALUE_BITS-1:0]            req_value,
   input  rdc_pkg::rdc_cmd_type             cmd,
   output rdc_pkg::rdc_status_type          status,
   output logic [rdc_pkg::DIGIT_BITS-1:0]   rsp_digit,
   output logic                             rsp_last_digit
);
   import rdc_pkg::*;

   localparam int STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_W  = STEPS * STEP_BITS;
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);

   logic [DIGIT_BITS-1:0] radix_ff;
   logic [DIGIT_BITS-1:0] radix_in;
   logic [DIV_W-1:0]      quot_ff;
   logic [DIV_W-1:0]      quot_in;
   logic [DIGIT_BITS-1:0] rem_ff;
   logic [DIGIT_BITS-1:0] rem_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_dec;
   logic [DIGIT_BITS-1:0] rd_ff;
   logic [DIGIT_BITS-1:0] digit_ff;
   logic                  last_ff;
   logic [DIGIT_BITS-1:0] stack_mem [MAX_DIGITS];

   // Clamp radix writes into the legal range
   always_comb begin
      if (csr_write_data < RADIX_MIN) begin
         radix_in = RADIX_MIN;
      end else if (csr_write_data > RADIX_MAX) begin
         radix_in = RADIX_MAX;
      end else begin
         radix_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_write_en) begin
         radix_ff <= radix_in;
      end
   end

   // One divider cycle: STEP_BITS restoring steps, remainder stays below radix
   always_comb begin
      logic [DIV_W-1:0]      q;
      logic [DIGIT_BITS-1:0] r;
      logic [DIGIT_BITS:0]   part;
      logic [DIGIT_BITS:0]   diff;
      q = quot_ff;
      r = rem_ff;
      for (int i = 0; i < STEP_BITS; i++) begin
         part = {r, q[DIV_W-1]};
         q    = {q[DIV_W-2:0], 1'b0};
         diff = part - {1'b0, radix_ff};
         if (part >= {1'b0, radix_ff}) begin
            r    = diff[DIGIT_BITS-1:0];
            q[0] = 1'b1;
         end else begin
            r = part[DIGIT_BITS-1:0];
         end
      end
      quot_in = q;
      rem_in  = r;
   end

   assign count_dec = count_ff - CNT_W'(1);

   // Load the word, advance the divider
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quot_ff <= DIV_W'(req_value);
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= cmd.push ? '0 : rem_in;
      end
   end

   // Stack depth
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= '0;
      end else if (cmd.push) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_ff <= count_dec;
      end
   end

   // Push a remainder digit
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[count_ff[ADDR_W-1:0]] <= rem_in;
      end
   end

   // Pop the top digit
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rd_ff <= stack_mem[count_dec[ADDR_W-1:0]];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.show) begin
         digit_ff <= rd_ff;
         last_ff  <= (count_ff == '0);
      end
   end

   assign status.quot_zero = (quot_ff == '0);
   assign status.full      = (count_ff == CNT_W'(MAX_DIGITS));
   assign status.last      = last_ff;

   assign rsp_digit      = digit_ff;
   assign rsp_last_digit = last_ff;

endmodule

FILE: rtl/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl
// Controller: sequences the divider cycles per digit, then pops the digit
// stack and hands out the digits one at a time on the result channel.
// ----------------------------------------------------------------------------
module rdc_ctrl #(
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rdc_pkg::rdc_status_type status,
   output rdc_pkg::rdc_cmd_type    cmd
);
   import rdc_pkg::*;

   localparam int STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int STEP_W = $clog2(STEPS + 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_TEST,
      ST_POP,
      ST_SHOW,
      ST_WAIT
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == LAST_STEP) begin
               cmd.push = 1'b1;
               state_in = ST_TEST;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_TEST: begin
            if (status.quot_zero || status.full) begin
               state_in = ST_POP;
            end else begin
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            cmd.show = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            // On hand-off, drop back to idle or fetch the next digit at once
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.pop  = 1'b1;
                  state_in = ST_SHOW;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (state_in == ST_WAIT);

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/radix_digit_converter_unit.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_unit
// Converts an unsigned word into its digits in a programmable base (2..10),
// most significant digit first, with a flag on the final digit.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_value
//   rsp      out        rsp_valid / rsp_ready     rsp_digit, rsp_last_digit
//   csr      in         csr_write_en              csr_write_data (radix)
//
// One word is converted at a time; req_ready is high only while idle.
// Each digit is worked out by the shared divider, which resolves eight
// quotient bits per cycle while it runs. Every digit then passes through
// the stack pop and the result register before it is shown on rsp.
// A low rsp_ready holds the current digit and the block.
// Reset is synchronous and sets the radix to 10.
// ----------------------------------------------------------------------------
module radix_digit_converter_unit #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [rdc_pkg::DIGIT_BITS-1:0] csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [VALUE_BITS-1:0]          req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rdc_pkg::DIGIT_BITS-1:0] rsp_digit,
   output logic                           rsp_last_digit
);
   import rdc_pkg::*;

   rdc_cmd_type    cmd;
   rdc_status_type status;

   // Sequencer
   rdc_ctrl #(
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Divider, digit stack and result register
   rdc_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_digit      (rsp_digit),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

FILE: rtl/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks of the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
module rdc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rdc_pkg::DIGIT_BITS-1:0] rsp_digit,
   input logic                           rsp_last_digit
);
   import rdc_pkg::*;

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit) && $stable(rsp_last_digit))
      else $error("stalled result word changed");

   // A digit stays below the largest base
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit < RADIX_MAX)
      else $error("digit out of range");

   // Take one word at a time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

   // No result pending while idle
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("result shown while idle");

   // Return to idle right after the final digit
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_digit |=> req_ready && !rsp_valid)
      else $error("not idle after final digit");

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_digit      (rsp_digit),
   .rsp_last_digit (rsp_last_digit)
);

FILE: tb/sv/radix_digit_converter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_unit_tb
// Drives words into the radix digit converter under a range of bases and
// handshake pressure, predicts the digit sequence of every accepted word and
// checks each digit and its last flag in order as it leaves the block.
// ----------------------------------------------------------------------------
module radix_digit_converter_unit_tb;

   import rdc_pkg::*;

   localparam int VALUE_BITS   = 32;
   localparam int MAX_DIGITS   = 32;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_WORDS  = 20;
   localparam int REPORT_LIMIT = 10;

   typedef logic [DIGIT_BITS-1:0] digit_type;
   typedef logic [VALUE_BITS-1:0] word_type;

   typedef struct {
      digit_type digit;
      logic      last;
   } digit_entry_type;

   // Expected digit stream and checking
   class digit_scoreboard;
      digit_entry_type expected_digits[$];
      int words_noted;
      int digits_checked;
      int mismatch_count;

      function int pending();
         return expected_digits.size();
      endfunction

      // Divide down least significant digit first, then emit in reverse order
      function void note_word(word_type value, digit_type base);
         logic [63:0]     rest;
         digit_type       stack[$];
         digit_entry_type entry;
         rest = value;
         do begin
            if (stack.size() >= MAX_DIGITS)
               break;
            stack.push_back(digit_type'(rest % base));
            rest = rest / base;
         end while (rest != 0);
         while (stack.size() > 0) begin
            entry.digit = stack.pop_back();
            entry.last  = (stack.size() == 0);
            expected_digits.push_back(entry);
         end
         words_noted++;
      endfunction

      function void check_digit(digit_type digit, logic last);
         digit_entry_type want;
         if (expected_digits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected digit %0d last %0b with nothing pending", digit, last);
            return;
         end
         want = expected_digits.pop_front();
         digits_checked++;
         if (digit !== want.digit || last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("digit %0d: expected digit %0d last %0b, got digit %0d last %0b",
                        digits_checked, want.digit, want.last, digit, last);
         end
      endfunction
   endclass

   logic      clock          = 1'b0;
   logic      reset          = 1'b1;
   logic      csr_write_en   = 1'b0;
   digit_type csr_write_data = '0;
   logic      req_valid      = 1'b0;
   logic      req_ready;
   word_type  req_value      = '0;
   logic      rsp_valid;
   logic      rsp_ready      = 1'b0;
   digit_type rsp_digit;
   logic      rsp_last_digit;

   digit_scoreboard sb = new();
   digit_type radix_now   = RADIX_RESET;
   int        req_idle_pct  = 0;
   int        rsp_stall_pct = 0;
   int        radix_writes  = 0;
   int        cycle_count   = 0;

   radix_digit_converter_unit #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_DIGITS(MAX_DIGITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit      (rsp_digit),
      .rsp_last_digit (rsp_last_digit)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Check accepted digits, then pick the next ready level
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         sb.check_digit(rsp_digit, rsp_last_digit);
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d digits pending", cycle_count, sb.pending());
         $display("radix_digit_converter_unit: mismatch");
         $finish;
      end
   end

   function automatic void set_idling(int mode);
      case (mode % 4)
         0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin req_idle_pct = 69; rsp_stall_pct = 0;  end
         2: begin req_idle_pct = 0;  rsp_stall_pct = 69; end
         default: begin req_idle_pct = 37; rsp_stall_pct = 37; end
      endcase
   endfunction

   // Mix of edge words, powers of the base and words of every length
   function automatic word_type random_word();
      int          pick;
      int          k;
      logic [63:0] p;
      pick = $urandom_range(0, 9);
      p = 1;
      case (pick)
         0: return '0;
         1: return '1;
         2, 3: begin
            k = $urandom_range(1, 31);
            repeat (k)
               if (p * radix_now <= 64'hFFFF_FFFF)
                  p = p * radix_now;
            return word_type'(p - $urandom_range(0, 1));
         end
         4, 5: return $urandom();
         default: return $urandom() >> $urandom_range(0, 31);
      endcase
   endfunction

   // Present one word after an optional idle gap and hold it until taken
   task automatic send_word(input word_type value);
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_word(value, radix_now);
   endtask

   // Drop valid and wait until every expected digit has come out
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the base register while idle; track the clamped value
   task automatic write_radix(input digit_type code);
      wait_for_drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= code;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      if (code < RADIX_MIN)
         radix_now = RADIX_MIN;
      else if (code > RADIX_MAX)
         radix_now = RADIX_MAX;
      else
         radix_now = code;
      radix_writes++;
   endtask

   task automatic send_batch(input word_type values[$]);
      foreach (values[i])
         send_word(values[i]);
   endtask

   digit_type phase_codes[10] = '{4'd2, 4'd15, 4'd0, 4'd7, 4'd11, 4'd3, 4'd1, 4'd5, 4'd10, 4'd9};

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: edges of the value range, base boundaries, clamped writes
      set_idling(0);
      send_batch('{32'd0, 32'd1, 32'd9, 32'd10, 32'hFFFF_FFFF, 32'd1000000000});
      write_radix(4'd2);
      send_batch('{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555});
      write_radix(4'd0);
      send_batch('{32'd3});
      write_radix(4'd1);
      send_batch('{32'd6});
      write_radix(4'd9);
      send_batch('{32'd8, 32'd9, 32'd81});
      write_radix(4'd15);
      send_batch('{32'd12345});
      write_radix(4'd11);
      send_batch('{32'd100});
      write_radix(4'd3);
      send_batch('{32'hFFFF_FFFF, 32'd2});
      write_radix(4'd8);
      send_batch('{32'd0, 32'd7});

      // Random phases: new base and new idling pattern each phase
      for (int ph = 0; ph < 10; ph++) begin
         if (ph >= 6 && $urandom_range(0, 1))
            write_radix(digit_type'($urandom_range(0, 15)));
         else
            write_radix(phase_codes[ph]);
         set_idling(ph);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (ph == 3 && n == PHASE_WORDS / 2)
               wait_for_drain();
            send_word(random_word());
         end
      end

      wait_for_drain();
      repeat (250) @(posedge clock);

      $display("converted %0d words into %0d digits over %0d base writes,",
               sb.words_noted, sb.digits_checked, radix_writes);
      $display("bases 2 to 10 with clamped codes, idle and stall pressure on both sides");
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("radix_digit_converter_unit: match");
      end else begin
         $display("%0d mismatches, %0d digits never seen", sb.mismatch_count, sb.pending());
         $display("radix_digit_converter_unit: mismatch");
      end
      $finish;
   end

endmodule
